### rtl/sqmix_pkg.sv
package sqmix_pkg;

  // sample_bucket + cycles stays below 2048
  localparam int BUCKET_W = 11;
  localparam int CYC_W    = 10;
  localparam int TIMER_W  = 24;

  localparam logic [7:0] OFS_DUTY_VOL = 8'h62;
  localparam logic [7:0] OFS_FREQ     = 8'h64;
  localparam logic [7:0] OFS_MIX      = 8'h82;

  localparam logic OP_WRITE   = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  localparam int MIX_A_FULL  = 2;
  localparam int MIX_B_FULL  = 3;
  localparam int MIX_A_RIGHT = 8;
  localparam int MIX_A_LEFT  = 9;
  localparam int MIX_B_RIGHT = 12;
  localparam int MIX_B_LEFT  = 13;

  localparam logic [8:0] VOL_STEP = 9'd500;

  typedef struct packed {
    logic        enabled;
    logic [1:0]  duty_select;
    logic [2:0]  duty_position;
    logic [3:0]  volume_level;
    logic [15:0] mix_control;
  } mix_cfg_t;

  typedef struct packed {
    logic                done;
    logic [1:0]          count;
    logic [BUCKET_W-1:0] rem;
  } div_res_t;

  // number of high steps out of eight for each duty setting
  function automatic logic [2:0] duty_high_len(input logic [1:0] sel);
    logic [2:0] len;
    case (sel)
      2'd0:    len = 3'd1;
      2'd1:    len = 3'd2;
      2'd2:    len = 3'd4;
      2'd3:    len = 3'd6;
      default: len = 3'd1;
    endcase
    return len;
  endfunction

endpackage

### rtl/square_channel_with_stereo_mixer.sv
// Square tone channel with stereo mixer.
//
// Input channel (s_*): one transaction is a register write (s_tuser = 0) or
// a time advance (s_tuser = 1). A write to 0x62, 0x64 or 0x82 updates the
// tone or mix settings; other offsets are ignored. Writes produce nothing
// and can follow each other back to back.
// Output channel (m_*): an advance produces up to three stereo samples, one
// per whole SAMPLE_PERIOD in the bucket; m_tlast marks the final one.
// Advance steps: split the bucket (load, reciprocal multiply, then
// remainder), emit the samples, then update the tone timer (subtract,
// then reload).
// s_tready is low from an advance until the item is finished.
// All samples of one advance carry the same value, captured at accept.
// Reset clears all settings, the bucket, the timer and the output valid.
// A stalled receiver holds the sequencer in the emit step; the output
// register keeps its sample until taken, and the next input is taken while
// the final sample still waits.
module square_channel_with_stereo_mixer #(
  parameter int SAMPLE_PERIOD = 380
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // reg_offset[7:0], reg_value[23:8], cycles[33:24], fifo_a_sample[41:34],
  // fifo_b_sample[49:42], zero[55:50]
  input  logic [55:0] s_tdata,
  // op
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // left_sample[15:0], right_sample[31:16]
  output logic [31:0] m_tdata,
  output logic        m_tlast
);
  import sqmix_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT,
    ST_TIM_SUB,
    ST_TIM_RELOAD
  } state_t;

  state_t state;

  logic [7:0]              reg_offset;
  logic [15:0]             reg_value;
  logic [CYC_W-1:0]        cycles;
  logic signed [7:0]       fifo_a_sample;
  logic signed [7:0]       fifo_b_sample;

  logic                    channel_enabled;
  logic [1:0]              duty_select;
  logic [3:0]              volume_level;
  logic [10:0]             period_code;
  logic signed [TIMER_W-1:0] period_timer;
  logic [2:0]              duty_position;
  logic [15:0]             mix_control;
  logic [CYC_W-1:0]        sample_bucket;
  logic [CYC_W-1:0]        cyc_hold;
  logic [1:0]              left_cnt;

  logic                    in_accept;
  logic                    div_start;
  logic [BUCKET_W-1:0]     bucket_sum;
  div_res_t                div_res;
  mix_cfg_t                mix_cfg;
  logic signed [15:0]      mix_left;
  logic signed [15:0]      mix_right;
  logic [13:0]             reload;
  logic [13:0]             reload_next;
  logic signed [TIMER_W:0] timer_sub;

  assign reg_offset    = s_tdata[7:0];
  assign reg_value     = s_tdata[23:8];
  assign cycles        = s_tdata[33:24];
  assign fifo_a_sample = s_tdata[41:34];
  assign fifo_b_sample = s_tdata[49:42];

  assign s_tready   = (state == ST_IDLE);
  assign in_accept  = s_tvalid && s_tready;
  assign div_start  = in_accept && (s_tuser == OP_ADVANCE);
  assign bucket_sum = BUCKET_W'(sample_bucket) + BUCKET_W'(cycles);

  assign mix_cfg.enabled       = channel_enabled;
  assign mix_cfg.duty_select   = duty_select;
  assign mix_cfg.duty_position = duty_position;
  assign mix_cfg.volume_level  = volume_level;
  assign mix_cfg.mix_control   = mix_control;

  // (2048 - code) * 4
  assign reload      = {12'd2048 - {1'b0, period_code}, 2'b00};
  assign reload_next = {12'd2048 - {1'b0, reg_value[10:0]}, 2'b00};
  assign timer_sub   = (TIMER_W+1)'(period_timer) - $signed({15'd0, cyc_hold});

  sqmix_divider #(
    .SAMPLE_PERIOD(SAMPLE_PERIOD)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .bucket_in(bucket_sum),
    .res      (div_res)
  );

  sqmix_mixer u_mix (
    .clk          (clk),
    .load         (div_start),
    .cfg          (mix_cfg),
    .fifo_a_sample(fifo_a_sample),
    .fifo_b_sample(fifo_b_sample),
    .left_sample  (mix_left),
    .right_sample (mix_right)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      channel_enabled <= 1'b0;
      duty_select     <= '0;
      volume_level    <= '0;
      period_code     <= '0;
      period_timer    <= '0;
      duty_position   <= '0;
      mix_control     <= '0;
      sample_bucket   <= '0;
      left_cnt        <= '0;
      m_tvalid        <= 1'b0;
      m_tlast         <= 1'b0;
    end else begin
      // the emit step drives its own valid
      if (m_tready && (state != ST_EMIT)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_accept) begin
            if (s_tuser == OP_WRITE) begin
              case (reg_offset)
                OFS_DUTY_VOL: begin
                  duty_select  <= reg_value[7:6];
                  volume_level <= reg_value[15:12];
                end
                OFS_FREQ: begin
                  period_code <= reg_value[10:0];
                  if (reg_value[15]) begin
                    channel_enabled <= 1'b1;
                    period_timer    <= TIMER_W'(reload_next);
                    duty_position   <= '0;
                  end
                end
                OFS_MIX: begin
                  mix_control <= reg_value;
                end
                default: begin
                end
              endcase
            end else begin
              cyc_hold <= cycles;
              state    <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (div_res.done) begin
            sample_bucket <= div_res.rem[CYC_W-1:0];
            left_cnt      <= div_res.count;
            state         <= (div_res.count == 2'd0) ? ST_TIM_SUB : ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {mix_right, mix_left};
            m_tlast  <= (left_cnt == 2'd1);
            left_cnt <= left_cnt - 2'd1;
            if (left_cnt == 2'd1) begin
              state <= ST_TIM_SUB;
            end
          end
        end
        ST_TIM_SUB: begin
          // floor at -2^23
          if (channel_enabled) begin
            if (timer_sub < -(TIMER_W+1)'(signed'(1 <<< (TIMER_W-1)))) begin
              period_timer <= {1'b1, {(TIMER_W-1){1'b0}}};
            end else begin
              period_timer <= timer_sub[TIMER_W-1:0];
            end
          end
          state <= ST_TIM_RELOAD;
        end
        ST_TIM_RELOAD: begin
          if (channel_enabled && (period_timer <= 0)) begin
            period_timer  <= period_timer + $signed({10'd0, reload});
            duty_position <= duty_position + 3'd1;
          end
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/sqmix_divider.sv
module sqmix_divider #(
  parameter int SAMPLE_PERIOD = 380
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [sqmix_pkg::BUCKET_W-1:0] bucket_in,
  output sqmix_pkg::div_res_t           res
);
  import sqmix_pkg::*;

  // quotient by reciprocal multiply; exact for any bucket below 2^11
  localparam int RECIP_SHIFT = 22;
  localparam int RECIP_W     = 19;
  localparam int PROD_W      = BUCKET_W + RECIP_W;

  localparam logic [BUCKET_W-1:0] PERIOD = BUCKET_W'(SAMPLE_PERIOD);
  localparam logic [RECIP_W-1:0]  RECIP  =
    RECIP_W'((1 << RECIP_SHIFT) / SAMPLE_PERIOD + 1);

  logic                mul_go;
  logic                fix_go;
  logic [BUCKET_W-1:0] num;
  logic [PROD_W-1:0]   prod;
  logic [7:0]          quo;
  logic [BUCKET_W+7:0] quo_x_period;
  logic [BUCKET_W-1:0] rem;
  logic [1:0]          count;
  logic                done;

  assign quo          = prod[PROD_W-1:RECIP_SHIFT];
  assign quo_x_period = {{BUCKET_W{1'b0}}, quo} * {8'd0, PERIOD};

  // load, multiply, then remainder and sample count (saturates at three)
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_go <= 1'b0;
      fix_go <= 1'b0;
      done   <= 1'b0;
      num    <= '0;
      prod   <= '0;
      rem    <= '0;
      count  <= '0;
    end else begin
      mul_go <= start;
      fix_go <= mul_go;
      done   <= fix_go;
      if (start) begin
        num <= bucket_in;
      end
      if (mul_go) begin
        prod <= {{RECIP_W{1'b0}}, num} * {{BUCKET_W{1'b0}}, RECIP};
      end
      if (fix_go) begin
        rem   <= num - quo_x_period[BUCKET_W-1:0];
        count <= (quo > 8'd3) ? 2'd3 : quo[1:0];
      end
    end
  end

  assign res.done  = done;
  assign res.count = count;
  assign res.rem   = rem;

endmodule

### rtl/sqmix_mixer.sv
module sqmix_mixer (
  input  logic                clk,
  input  logic                load,
  input  sqmix_pkg::mix_cfg_t cfg,
  input  logic signed [7:0]   fifo_a_sample,
  input  logic signed [7:0]   fifo_b_sample,
  output logic signed [15:0]  left_sample,
  output logic signed [15:0]  right_sample
);
  import sqmix_pkg::*;

  logic signed [8:0]  a_half;
  logic signed [8:0]  b_half;
  logic signed [8:0]  a_val;
  logic signed [8:0]  b_val;
  logic signed [9:0]  dl;
  logic signed [9:0]  dr;
  logic [13:0]        amp;
  logic signed [14:0] sq;
  logic signed [16:0] l_sum;
  logic signed [16:0] r_sum;

  function automatic logic signed [15:0] sat16(input logic signed [16:0] x);
    logic signed [15:0] y;
    if (x > 17'sd32767) begin
      y = 16'sh7fff;
    end else if (x < -17'sd32768) begin
      y = 16'sh8000;
    end else begin
      y = x[15:0];
    end
    return y;
  endfunction

  always_comb begin
    // halve toward zero
    a_half = (9'(fifo_a_sample) + $signed({8'd0, fifo_a_sample[7]})) >>> 1;
    b_half = (9'(fifo_b_sample) + $signed({8'd0, fifo_b_sample[7]})) >>> 1;
    a_val  = cfg.mix_control[MIX_A_FULL] ? 9'(fifo_a_sample) : a_half;
    b_val  = cfg.mix_control[MIX_B_FULL] ? 9'(fifo_b_sample) : b_half;
    dl = (cfg.mix_control[MIX_A_LEFT]  ? 10'(a_val) : 10'sd0)
       + (cfg.mix_control[MIX_B_LEFT]  ? 10'(b_val) : 10'sd0);
    dr = (cfg.mix_control[MIX_A_RIGHT] ? 10'(a_val) : 10'sd0)
       + (cfg.mix_control[MIX_B_RIGHT] ? 10'(b_val) : 10'sd0);
    amp = 14'(cfg.volume_level) * 14'(VOL_STEP);
    if (!cfg.enabled) begin
      sq = '0;
    end else if (cfg.duty_position < duty_high_len(cfg.duty_select)) begin
      sq = $signed({1'b0, amp});
    end else begin
      sq = -$signed({1'b0, amp});
    end
    l_sum = 17'(sq) + (17'(dl) <<< 6);
    r_sum = 17'(sq) + (17'(dr) <<< 6);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      left_sample  <= sat16(l_sum);
      right_sample <= sat16(r_sum);
    end
  end

endmodule

### rtl/sqmix_checker.sv
module sqmix_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tlast
);
  import sqmix_pkg::*;

  // stalled output holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output changed while stalled");

  // a register write never starts output
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == OP_WRITE) |=> !$rose(m_tvalid))
    else $error("output after register write");

  // an advance keeps the input side busy
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == OP_ADVANCE) |=> !s_tready)
    else $error("input ready right after advance");

  // more samples of the run are still to come
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> !s_tready)
    else $error("input ready before run ended");

  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind square_channel_with_stereo_mixer sqmix_checker u_sqmix_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .s_tuser (s_tuser),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tlast (m_tlast)
);

### verif/tb_square_channel_with_stereo_mixer.sv
module tb_square_channel_with_stereo_mixer;
  import sqmix_pkg::*;

  localparam int SAMPLE_PERIOD = 380;
  localparam int MAX_SAMPLES   = 3;
  localparam int TIMER_FLOOR   = -(1 << 23);
  localparam int WATCHDOG      = 5000;
  localparam int RANDOM_ITEMS  = 100;  // per idling phase, four phases

  typedef struct {
    logic               op;
    logic [7:0]         ofs;
    logic [15:0]        val;
    logic [9:0]         cyc;
    logic signed [7:0]  fa;
    logic signed [7:0]  fb;
    bit                 hold;  // wait for all pending samples before sending
  } apu_item_t;

  typedef struct {
    logic [15:0] left;
    logic [15:0] right;
    logic        is_last;
  } stereo_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tlast;

  square_channel_with_stereo_mixer #(
    .SAMPLE_PERIOD(SAMPLE_PERIOD)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  apu_item_t pending_q[$];
  stereo_t   sample_expect_q[$];
  apu_item_t cur_item;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        bad_count = 0;
  int        idle_cycles = 0;
  bit        take;

  // predictor copy of the channel and mixer state
  bit          tone_on;
  logic [1:0]  duty_sel;
  logic [3:0]  vol;
  logic [10:0] freq_code;
  int          tone_timer;
  logic [2:0]  duty_step;
  logic [15:0] mix_ctl;
  int          bucket_cnt;

  task automatic predict_samples(input apu_item_t it);
    int      acc;
    int      n;
    int      sq;
    int      av;
    int      bv;
    int      dl;
    int      dr;
    int      l;
    int      r;
    int      t;
    int      high_len;
    stereo_t s;
    acc = 0;
    n = 0;
    dl = 0;
    dr = 0;
    if (it.op == OP_WRITE) begin
      if (it.ofs == OFS_DUTY_VOL) begin
        duty_sel = it.val[7:6];
        vol = it.val[15:12];
      end else if (it.ofs == OFS_FREQ) begin
        freq_code = it.val[10:0];
        if (it.val[15]) begin
          tone_on = 1'b1;
          tone_timer = (2048 - int'(freq_code)) * 4;
          duty_step = '0;
        end
      end else if (it.ofs == OFS_MIX) begin
        mix_ctl = it.val;
      end
      return;
    end

    // every sample of one advance carries the same mix
    case (duty_sel)
      2'd0: high_len = 1;
      2'd1: high_len = 2;
      2'd2: high_len = 4;
      default: high_len = 6;
    endcase
    sq = 0;
    if (tone_on) begin
      sq = int'(vol) * int'(VOL_STEP);
      if (int'(duty_step) >= high_len) sq = -sq;
    end
    av = it.fa;
    bv = it.fb;
    if (!mix_ctl[MIX_A_FULL]) av = av / 2;
    if (!mix_ctl[MIX_B_FULL]) bv = bv / 2;
    if (mix_ctl[MIX_A_RIGHT]) dr += av;
    if (mix_ctl[MIX_A_LEFT])  dl += av;
    if (mix_ctl[MIX_B_RIGHT]) dr += bv;
    if (mix_ctl[MIX_B_LEFT])  dl += bv;
    l = sq + dl * 64;
    r = sq + dr * 64;
    if (l > 32767) l = 32767;
    if (l < -32768) l = -32768;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;

    acc = bucket_cnt + int'(it.cyc);
    while (acc >= SAMPLE_PERIOD && n < MAX_SAMPLES) begin
      acc -= SAMPLE_PERIOD;
      n++;
    end
    bucket_cnt = acc % SAMPLE_PERIOD;
    for (int k = 0; k < n; k++) begin
      s.left = l[15:0];
      s.right = r[15:0];
      s.is_last = (k == n - 1);
      sample_expect_q.insert(sample_expect_q.size(), s);
    end

    if (tone_on) begin
      t = tone_timer - int'(it.cyc);
      if (t < TIMER_FLOOR) t = TIMER_FLOOR;
      if (t <= 0) begin
        t += (2048 - int'(freq_code)) * 4;
        duty_step = duty_step + 3'd1;
      end
      tone_timer = t;
    end
  endtask

  // driver: one transaction per handshake, prediction made at accept
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) predict_samples(cur_item);
      if (!s_tvalid || s_tready) begin
        take = pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct;
        if (take && pending_q[0].hold && sample_expect_q.size() > 0) take = 1'b0;
        if (take) begin
          cur_item = pending_q.pop_front();
          s_tdata <= {6'b0, cur_item.fb, cur_item.fa, cur_item.cyc, cur_item.val,
                      cur_item.ofs};
          s_tuser <= cur_item.op;
        end
        s_tvalid <= take;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    stereo_t e;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (sample_expect_q.size() == 0) begin
          $error("unexpected sample: left %0d right %0d", $signed(m_tdata[15:0]),
                 $signed(m_tdata[31:16]));
          bad_count++;
        end else begin
          e = sample_expect_q.pop_front();
          if (m_tdata[15:0] !== e.left) begin
            $error("left_sample: expected %0d, actual %0d", $signed(e.left),
                   $signed(m_tdata[15:0]));
            bad_count++;
          end
          if (m_tdata[31:16] !== e.right) begin
            $error("right_sample: expected %0d, actual %0d", $signed(e.right),
                   $signed(m_tdata[31:16]));
            bad_count++;
          end
          if (m_tlast !== e.is_last) begin
            $error("last_of_run: expected %0d, actual %0d", e.is_last, m_tlast);
            bad_count++;
          end
        end
      end
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic push_item(input logic op, input logic [7:0] ofs, input logic [15:0] val,
                           input logic [9:0] cyc, input int a, input int b,
                           input bit hold);
    apu_item_t it;
    it.op = op;
    it.ofs = ofs;
    it.val = val;
    it.cyc = cyc;
    it.fa = a[7:0];
    it.fb = b[7:0];
    it.hold = hold;
    pending_q.insert(pending_q.size(), it);
  endtask

  task automatic reg_write(input logic [7:0] ofs, input logic [15:0] val, input bit hold);
    push_item(OP_WRITE, ofs, val, 10'($urandom_range(1023)), $urandom_range(255),
              $urandom_range(255), hold);
  endtask

  task automatic advance(input logic [9:0] cyc, input int a, input int b, input bit hold);
    push_item(OP_ADVANCE, 8'($urandom_range(255)), 16'($urandom_range(65535)), cyc, a, b,
              hold);
  endtask

  task automatic drain_all();
    while (pending_q.size() > 0 || s_tvalid || sample_expect_q.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    int          sel;
    bit          hold;
    logic [7:0]  junk_ofs;
    logic [15:0] v;

    tone_on = 1'b0;
    duty_sel = '0;
    vol = '0;
    freq_code = '0;
    tone_timer = 0;
    duty_step = '0;
    mix_ctl = '0;
    bucket_cnt = 0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: zero advance, bucket edge, mix scaling and pan, all duties,
    // three samples from one advance, ignored offset
    advance(10'd0, 5, -5, 1'b0);
    advance(10'd379, 0, 0, 1'b0);
    advance(10'd1, -128, 127, 1'b0);
    reg_write(OFS_MIX, 16'h330C, 1'b0);
    advance(10'd380, 127, 127, 1'b0);
    reg_write(OFS_MIX, 16'h3300, 1'b0);
    advance(10'd380, -128, -1, 1'b0);
    reg_write(OFS_DUTY_VOL, 16'hF0C0, 1'b0);
    reg_write(OFS_FREQ, 16'h87FF, 1'b0);
    advance(10'd379, 1, 1, 1'b0);
    advance(10'd1023, -128, -128, 1'b0);
    reg_write(8'h63, 16'hFFFF, 1'b0);
    reg_write(OFS_FREQ, 16'h0000, 1'b0);
    reg_write(OFS_MIX, 16'h1200, 1'b0);
    advance(10'd1023, 127, -128, 1'b0);
    reg_write(OFS_DUTY_VOL, 16'h0000, 1'b0);
    advance(10'd500, -3, 3, 1'b0);
    reg_write(OFS_DUTY_VOL, 16'h5040, 1'b0);
    reg_write(OFS_FREQ, 16'h8000, 1'b0);
    advance(10'd760, 64, -64, 1'b0);
    reg_write(OFS_DUTY_VOL, 16'hA080, 1'b0);
    reg_write(OFS_MIX, 16'hFFFF, 1'b0);
    advance(10'd1023, -1, 1, 1'b0);
    advance(10'd1023, 127, 127, 1'b0);
    drain_all();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
        hold = (i == 0) || ($urandom_range(49) == 0);
        // occasional write to an offset the block ignores
        if ($urandom_range(99) < 8) begin
          junk_ofs = 8'($urandom_range(255));
          if (junk_ofs != OFS_DUTY_VOL && junk_ofs != OFS_FREQ && junk_ofs != OFS_MIX)
            reg_write(junk_ofs, 16'($urandom_range(65535)), 1'b0);
        end
        sel = $urandom_range(99);
        v = 16'($urandom_range(65535));
        if (sel < 55) begin
          if ($urandom_range(9) == 0)
            advance(10'($urandom_range(20)), $urandom_range(255), $urandom_range(255), hold);
          else
            advance(10'($urandom_range(1023)), $urandom_range(255), $urandom_range(255),
                    hold);
        end else if (sel < 70) begin
          reg_write(OFS_DUTY_VOL, v, hold);
        end else if (sel < 85) begin
          // short periods make the duty step move often
          if ($urandom_range(1)) v[10:0] = 11'(2047 - $urandom_range(63));
          reg_write(OFS_FREQ, v, hold);
        end else begin
          reg_write(OFS_MIX, v, hold);
        end
      end
      drain_all();
    end

    repeat (20) @(posedge clk);
    if (sample_expect_q.size() > 0)
      $error("%0d expected samples never arrived", sample_expect_q.size());
    if (bad_count == 0 && sample_expect_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
